### src/assert_macros.svh
// Assertion macros shared by the block hash history table modules.
// Depends on nothing; expects ports named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define BHHT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define BHHT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### src/bhht_pkg.sv
// Shared types and constants for the block hash history table.
// Depends on nothing; imported by every module of the block.
package bhht_pkg;

   localparam int RECENT_DEPTH_DEF     = 256;
   localparam int CHECKPOINT_DEPTH_DEF = 32;
   localparam int MAX_RESULTS          = 64;
   localparam int HASH_W               = 256;
   localparam int HEIGHT_W             = 32;
   localparam int INTERVAL_W           = 20;
   localparam int DENSE_W              = 9;

   localparam logic [19:0] INTERVAL_RESET = 20'd5000;
   localparam logic [8:0]  DENSE_RESET    = 9'd10;

   // Request kinds.
   localparam logic [1:0] REQ_STORE   = 2'd0;
   localparam logic [1:0] REQ_FORGET  = 2'd1;
   localparam logic [1:0] REQ_LOOKUP  = 2'd2;
   localparam logic [1:0] REQ_LOCATOR = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_INTERVAL = 1'b0;
   localparam logic CSR_DENSE    = 1'b1;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic [HASH_W-1:0]   hash;
   } entry_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [HEIGHT_W-1:0] height;
      logic [HASH_W-1:0]   hash;
   } queue_item_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] interval;
      logic [DENSE_W-1:0]    dense;
   } cfg_type;

   typedef struct packed {
      logic                found;
      logic [HASH_W-1:0]   hash;
      logic                last;
      logic [HEIGHT_W-1:0] height;
   } rsp_item_type;

endpackage

### src/block_hash_history_table.sv
// Top level of the block hash history table: configuration registers and port packing.
// Depends on bhht_pkg, bhht_front and bhht_back.
//
//  channel  direction  handshake             tdata / tuser / tlast
//  req      in         req_tvalid/tready     height, hash words; kind
//  rsp      out        rsp_tvalid/tready     hash words, height; found; last
//  csr      in         csr_we                index, write data
//
// Forget and lookup walk the stored entries, bounded by the recent and checkpoint
// counts: the walk shares the one read port of each list memory. Locator fetches
// each hash before sending it. Reset is synchronous and needs no clearing pass.
// A stalled result holds the engine; the two-beat request queue keeps taking beats
// meanwhile until it is full.
module block_hash_history_table
   import bhht_pkg::*;
#(
   parameter int RECENT_DEPTH     = RECENT_DEPTH_DEF,
   parameter int CHECKPOINT_DEPTH = CHECKPOINT_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [19:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,   // height, hash_word0, hash_word1, hash_word2, hash_word3
   input  logic [1:0]   req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // out_word0, out_word1, out_word2, out_word3, current_height
   output logic [0:0]   rsp_tuser,   // found
   output logic         rsp_tlast
);

   cfg_type        cfg_ff, cfg_in;
   logic           q_valid, q_pop;
   queue_item_type q_item;
   rsp_item_type   rsp_item;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_INTERVAL: cfg_in.interval = csr_wdata;
            CSR_DENSE:    cfg_in.dense    = csr_wdata[DENSE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{interval: INTERVAL_RESET, dense: DENSE_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bhht_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_height (req_tdata[31:0]),
      .req_hash   (req_tdata[287:32]),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   bhht_back #(.RDEPTH(RECENT_DEPTH), .CDEPTH(CHECKPOINT_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_item   (rsp_item),
      .rsp_tready (rsp_tready)
   );

   // Result beat packing.
   assign rsp_tdata = {rsp_item.height, rsp_item.hash};
   assign rsp_tuser = rsp_item.found;
   assign rsp_tlast = rsp_item.last;

endmodule

### src/bhht_mem.sv
// Simple dual-port entry memory with registered read data.
// Depends on bhht_pkg for the entry type.
module bhht_mem
   import bhht_pkg::*;
#(
   parameter int DEPTH = RECENT_DEPTH_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bhht_front.sv
// Front end: accepts request beats and queues them, with their kind, for the engine.
// Depends on bhht_pkg for the queue item type and assert_macros.svh for the checks.
`include "assert_macros.svh"

module bhht_front
   import bhht_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_kind,
   input  logic [HEIGHT_W-1:0] req_height,
   input  logic [HASH_W-1:0]   req_hash,
   output logic                q_valid,
   output queue_item_type      q_item,
   input  logic                q_pop
);

   queue_item_type slot_ff [2];
   logic           wptr_ff, wptr_in;
   logic           rptr_ff, rptr_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           push;

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = slot_ff[rptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = ~wptr_ff;
      end
      if (q_pop) begin
         rptr_in = ~rptr_ff;
      end
      case ({push, q_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Slot storage; the request kind is kept as received for the engine.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= '{kind: req_kind, height: req_height, hash: req_hash};
      end
   end

   `BHHT_ASSERT(a_fifo_bound, cnt_ff <= 2'd2, "request queue over full")
   `BHHT_ASSERT(a_pop_nonempty, !(q_pop && (cnt_ff == 2'd0)), "pop from empty request queue")

endmodule

### src/bhht_back.sv
// Back end: the engine that updates and walks the recent and checkpoint lists.
// Depends on bhht_pkg and bhht_mem; both lists are circular buffers, newest at the head.
`include "assert_macros.svh"

module bhht_back
   import bhht_pkg::*;
#(
   parameter int RDEPTH = RECENT_DEPTH_DEF,
   parameter int CDEPTH = CHECKPOINT_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           q_valid,
   input  queue_item_type q_item,
   output logic           q_pop,
   output logic           rsp_valid,
   output rsp_item_type   rsp_item,
   input  logic           rsp_tready
);

   localparam int RAW = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
   localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
   localparam int RCW = $clog2(RDEPTH + 1);
   localparam int CCW = $clog2(CDEPTH + 1);
   localparam int IW  = ((RCW > CCW) ? RCW : CCW) + 1;

   localparam logic [IW:0] RLIM = (IW + 1)'(RDEPTH);
   localparam logic [IW:0] CLIM = (IW + 1)'(CDEPTH);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ST_RD   = 4'd1;
   localparam logic [3:0] S_ST_WR   = 4'd2;
   localparam logic [3:0] S_SCAN_R  = 4'd3;
   localparam logic [3:0] S_SCAN_C  = 4'd4;
   localparam logic [3:0] S_LC_RD   = 4'd5;
   localparam logic [3:0] S_LC_EMIT = 4'd6;
   localparam logic [3:0] S_OUT     = 4'd7;

   logic [3:0]          state_ff, state_in;
   queue_item_type      cur_ff, cur_in;
   logic [RAW-1:0]      rhead_ff, rhead_in;
   logic [RCW-1:0]      rcount_ff, rcount_in;
   logic [CAW-1:0]      chead_ff, chead_in;
   logic [CCW-1:0]      ccount_ff, ccount_in;
   logic [HEIGHT_W-1:0] known_ff, known_in;
   logic [HEIGHT_W-1:0] marker_ff, marker_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       k_ff, k_in;
   logic                rdv_ff, rdv_in;
   logic [IW-1:0]       step_ff, step_in;
   logic                atsz_ff, atsz_in;
   logic [6:0]          n_ff, n_in;
   logic                in_ckpt_ff, in_ckpt_in;
   logic                res_found_ff, res_found_in;
   logic [HASH_W-1:0]   res_hash_ff, res_hash_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   // Memory port signals.
   logic            r_wr_en, r_rd_en, c_wr_en, c_rd_en;
   logic [RAW-1:0]  r_wr_addr, r_rd_addr;
   logic [CAW-1:0]  c_wr_addr, c_rd_addr;
   entry_type       r_wr_data, c_wr_data, r_rd_data, c_rd_data;

   // Address helpers.
   logic [IW:0]     rhead_ext, chead_ext, r_at_idx, r_at_k, c_at_idx, c_at_k;
   logic [IW-1:0]   r_cnt_ext, c_cnt_ext;
   logic [RAW-1:0]  rhead_dec;
   logic [CAW-1:0]  chead_dec;
   logic            out_free;
   logic            out_stall;

   function automatic logic [IW:0] wrap_add(input logic [IW:0] a, input logic [IW:0] b,
                                            input logic [IW:0] lim);
      logic [IW:0] s;
      s = a + b;
      return (s >= lim) ? (s - lim) : s;
   endfunction

   assign rhead_ext = {{(IW + 1 - RAW){1'b0}}, rhead_ff};
   assign chead_ext = {{(IW + 1 - CAW){1'b0}}, chead_ff};
   assign r_at_idx  = wrap_add(rhead_ext, {1'b0, idx_ff}, RLIM);
   assign r_at_k    = wrap_add(rhead_ext, {1'b0, k_ff}, RLIM);
   assign c_at_idx  = wrap_add(chead_ext, {1'b0, idx_ff}, CLIM);
   assign c_at_k    = wrap_add(chead_ext, {1'b0, k_ff}, CLIM);
   assign r_cnt_ext = {{(IW - RCW){1'b0}}, rcount_ff};
   assign c_cnt_ext = {{(IW - CCW){1'b0}}, ccount_ff};
   assign rhead_dec = (rhead_ff == '0) ? RAW'(RDEPTH - 1) : (rhead_ff - 1'b1);
   assign chead_dec = (chead_ff == '0) ? CAW'(CDEPTH - 1) : (chead_ff - 1'b1);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign out_stall = (state_ff == S_OUT) && !out_free;

   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Engine sequencer.
   always_comb begin
      logic             dup;
      logic             ckpt;
      logic [HEIGHT_W-1:0] kh_new;
      entry_type        ent;
      logic             dense_hit;
      logic [IW-1:0]    step_new;
      logic             atsz_new;
      logic [IW:0]      nxt_i;
      logic [IW-1:0]    nxt_j;
      logic [6:0]       n_new;
      logic             more;

      state_in     = state_ff;
      cur_in       = cur_ff;
      rhead_in     = rhead_ff;
      rcount_in    = rcount_ff;
      chead_in     = chead_ff;
      ccount_in    = ccount_ff;
      known_in     = known_ff;
      marker_in    = marker_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      rdv_in       = rdv_ff;
      step_in      = step_ff;
      atsz_in      = atsz_ff;
      n_in         = n_ff;
      in_ckpt_in   = in_ckpt_ff;
      res_found_in = res_found_ff;
      res_hash_in  = res_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_item_in  = rsp_item_ff;

      r_wr_en   = 1'b0;
      r_wr_addr = r_at_k[RAW-1:0];
      r_wr_data = r_rd_data;
      r_rd_en   = 1'b0;
      r_rd_addr = r_at_idx[RAW-1:0];
      c_wr_en   = 1'b0;
      c_wr_addr = c_at_k[CAW-1:0];
      c_wr_data = c_rd_data;
      c_rd_en   = 1'b0;
      c_rd_addr = c_at_idx[CAW-1:0];

      dup       = 1'b0;
      ckpt      = 1'b0;
      kh_new    = known_ff;
      ent       = in_ckpt_ff ? c_rd_data : r_rd_data;
      dense_hit = (32'(idx_ff) + 32'd1) >= 32'(cfg.dense);
      step_new  = step_ff;
      atsz_new  = atsz_ff;
      nxt_i     = '0;
      nxt_j     = idx_ff + 1'b1;
      n_new     = n_ff + 7'd1;
      more      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cur_in     = q_item;
               idx_in     = '0;
               k_in       = '0;
               rdv_in     = 1'b0;
               step_in    = IW'(1);
               atsz_in    = 1'b0;
               n_in       = '0;
               in_ckpt_in = 1'b0;
               unique case (q_item.kind) inside
                  REQ_STORE:               state_in = S_ST_RD;
                  REQ_FORGET, REQ_LOOKUP:  state_in = S_SCAN_R;
                  default:                 state_in = S_LC_RD;
               endcase
            end
         end

         // Read the newest recent entry to catch a repeated hash.
         S_ST_RD: begin
            r_rd_en   = 1'b1;
            r_rd_addr = rhead_ff;
            state_in  = S_ST_WR;
         end

         S_ST_WR: begin
            dup      = (rcount_ff != '0) && (r_rd_data.hash == cur_ff.hash);
            ckpt     = ({1'b0, marker_ff} + 33'(cfg.interval)) < {1'b0, cur_ff.height};
            known_in = cur_ff.height;
            if (!dup) begin
               if (ckpt) begin
                  marker_in = cur_ff.height;
                  chead_in  = chead_dec;
                  c_wr_en   = 1'b1;
                  c_wr_addr = chead_dec;
                  c_wr_data = '{height: cur_ff.height, hash: cur_ff.hash};
                  if (ccount_ff < CCW'(CDEPTH)) begin
                     ccount_in = ccount_ff + 1'b1;
                  end
               end
               rhead_in  = rhead_dec;
               r_wr_en   = 1'b1;
               r_wr_addr = rhead_dec;
               r_wr_data = '{height: cur_ff.height, hash: cur_ff.hash};
               if (rcount_ff < RCW'(RDEPTH)) begin
                  rcount_in = rcount_ff + 1'b1;
               end
            end
            res_found_in = 1'b0;
            res_hash_in  = '0;
            state_in     = S_OUT;
         end

         // Pipelined walk of the recent list: one read issued and one entry checked a cycle.
         S_SCAN_R: begin
            rdv_in = 1'b0;
            if (idx_ff < r_cnt_ext) begin
               r_rd_en = 1'b1;
               idx_in  = idx_ff + 1'b1;
               rdv_in  = 1'b1;
            end
            if (rdv_ff) begin
               if (cur_ff.kind == REQ_FORGET) begin
                  if (r_rd_data.height < cur_ff.height) begin
                     r_wr_en = 1'b1;
                     k_in    = k_ff + 1'b1;
                  end
               end else if (r_rd_data.height == cur_ff.height) begin
                  res_found_in = 1'b1;
                  res_hash_in  = r_rd_data.hash;
                  rdv_in       = 1'b0;
                  state_in     = S_OUT;
               end
            end else if (!(idx_ff < r_cnt_ext)) begin
               if (cur_ff.kind == REQ_FORGET) begin
                  rcount_in = k_ff[RCW-1:0];
               end
               idx_in   = '0;
               k_in     = '0;
               state_in = S_SCAN_C;
            end
         end

         // Same walk over the checkpoint list, then the single result.
         S_SCAN_C: begin
            rdv_in = 1'b0;
            if (idx_ff < c_cnt_ext) begin
               c_rd_en = 1'b1;
               idx_in  = idx_ff + 1'b1;
               rdv_in  = 1'b1;
            end
            if (rdv_ff) begin
               if (cur_ff.kind == REQ_FORGET) begin
                  if (c_rd_data.height < cur_ff.height) begin
                     c_wr_en = 1'b1;
                     k_in    = k_ff + 1'b1;
                  end
               end else if (c_rd_data.height == cur_ff.height) begin
                  res_found_in = 1'b1;
                  res_hash_in  = c_rd_data.hash;
                  rdv_in       = 1'b0;
                  state_in     = S_OUT;
               end
            end else if (!(idx_ff < c_cnt_ext)) begin
               if (cur_ff.kind == REQ_FORGET) begin
                  ccount_in = k_ff[CCW-1:0];
                  if (known_ff >= cur_ff.height) begin
                     kh_new = (cur_ff.height == '0) ? '0 : (cur_ff.height - 1'b1);
                  end
                  known_in = kh_new;
                  if (marker_ff >= cur_ff.height) begin
                     marker_in = kh_new;
                  end
               end
               res_found_in = 1'b0;
               res_hash_in  = '0;
               state_in     = S_OUT;
            end
         end

         // Locator: fetch the next entry to send.
         S_LC_RD: begin
            if (!in_ckpt_ff) begin
               if (idx_ff < r_cnt_ext) begin
                  r_rd_en  = 1'b1;
                  state_in = S_LC_EMIT;
               end else begin
                  in_ckpt_in = 1'b1;
                  idx_in     = '0;
               end
            end else if (idx_ff < c_cnt_ext) begin
               c_rd_en  = 1'b1;
               state_in = S_LC_EMIT;
            end else begin
               // Both lists empty: a single empty result.
               res_found_in = 1'b0;
               res_hash_in  = '0;
               state_in     = S_OUT;
            end
         end

         // Locator: send the fetched hash, looking ahead to flag the final beat.
         S_LC_EMIT: begin
            if (out_free) begin
               if (!in_ckpt_ff) begin
                  if (dense_hit) begin
                     if (atsz_ff) begin
                        step_new = (step_ff >= IW'(RDEPTH)) ? step_ff : (step_ff << 1);
                        atsz_new = 1'b0;
                     end else begin
                        atsz_new = 1'b1;
                     end
                  end
                  nxt_i = {1'b0, idx_ff} + {1'b0, step_new};
                  more  = (n_new < 7'(MAX_RESULTS)) &&
                          ((nxt_i < {1'b0, r_cnt_ext}) || (ccount_ff != '0));
                  if (nxt_i < {1'b0, r_cnt_ext}) begin
                     idx_in = nxt_i[IW-1:0];
                  end else begin
                     idx_in     = '0;
                     in_ckpt_in = 1'b1;
                  end
               end else begin
                  more   = (n_new < 7'(MAX_RESULTS)) && (nxt_j < c_cnt_ext);
                  idx_in = nxt_j;
               end
               step_in      = step_new;
               atsz_in      = atsz_new;
               n_in         = n_new;
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{found: 1'b1, hash: ent.hash, last: !more, height: known_ff};
               state_in     = more ? S_LC_RD : S_IDLE;
            end
         end

         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{found: res_found_ff, hash: res_hash_ff, last: 1'b1,
                                height: known_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rhead_ff     <= '0;
         rcount_ff    <= '0;
         chead_ff     <= '0;
         ccount_ff    <= '0;
         known_ff     <= '0;
         marker_ff    <= '0;
         rdv_ff       <= 1'b0;
         n_ff         <= '0;
         in_ckpt_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rhead_ff     <= rhead_in;
         rcount_ff    <= rcount_in;
         chead_ff     <= chead_in;
         ccount_ff    <= ccount_in;
         known_ff     <= known_in;
         marker_ff    <= marker_in;
         rdv_ff       <= rdv_in;
         n_ff         <= n_in;
         in_ckpt_ff   <= in_ckpt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      step_ff      <= step_in;
      atsz_ff      <= atsz_in;
      res_found_ff <= res_found_in;
      res_hash_ff  <= res_hash_in;
      rsp_item_ff  <= rsp_item_in;
   end

   bhht_mem #(.DEPTH(RDEPTH), .AW(RAW)) u_recent (
      .clock   (clock),
      .wr_en   (r_wr_en),
      .wr_addr (r_wr_addr),
      .wr_data (r_wr_data),
      .rd_en   (r_rd_en),
      .rd_addr (r_rd_addr),
      .rd_data (r_rd_data)
   );

   bhht_mem #(.DEPTH(CDEPTH), .AW(CAW)) u_ckpt (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_en   (c_rd_en),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   `BHHT_ASSERT(a_rcount_bound, rcount_ff <= RCW'(RDEPTH), "recent count above depth")
   `BHHT_ASSERT(a_ccount_bound, ccount_ff <= CCW'(CDEPTH), "checkpoint count above depth")
   `BHHT_ASSERT(a_emit_bound, n_ff <= 7'(MAX_RESULTS), "locator sent too many beats")
   `BHHT_ASSERT_NEXT(a_out_hold, out_stall, state_ff == S_OUT, "result left while stalled")

endmodule
